### rtl/cca_pkg.sv
`timescale 1ns / 1ps

package cca_pkg;

   localparam int MAX_CORES_DEF = 64;

   localparam int CORE_COUNT_W = 7;
   localparam int TEMP_W       = 16;
   localparam int MASK_W       = 64;
   localparam int CORE_IDX_W   = 6;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CORE_COUNT_W-1:0] CORE_COUNT_RST = 7'd64;
   localparam logic signed [TEMP_W-1:0] CRIT_TEMP_RST = 16'sd1280;

   typedef enum logic [1:0] {
      REQ_SAMPLE  = 2'd0,
      REQ_ALLOC   = 2'd1,
      REQ_MIGRATE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_GRANT   = 2'd0,
      KIND_FAIL    = 2'd1,
      KIND_MIGRATE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CORE_COUNT = 2'd0,
      CSR_CRIT_TEMP  = 2'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_BEST = 2'd1,
      SEL_PEND = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [CORE_IDX_W-1:0]    core_index;
      logic signed [TEMP_W-1:0] temperature;
      logic [CORE_COUNT_W-1:0]  core_requirement;
      logic [MASK_W-1:0]        available_mask;
      logic [MASK_W-1:0]        free_mask;
      logic [MASK_W-1:0]        active_mask;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            result_kind;
      logic [CORE_IDX_W-1:0] target_core;
      logic [CORE_IDX_W-1:0] source_core;
      logic                  last;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [TEMP_W-1:0]    data;
   } csr_item_type;

   // controller to datapath
   typedef struct packed {
      logic        accept_sample;
      logic        accept_alloc;
      logic        accept_migr;
      logic        count_step;
      logic        scan_start;
      logic        scan_step;
      logic        rd_core;
      logic        take_best;
      logic        store_pend;
      logic        next_core;
      logic        emit;
      kind_type    kind;
      out_sel_type sel;
      logic        last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic need_zero;
      logic need_one;
      logic have_enough;
      logic core_end;
      logic core_active;
      logic hot;
      logic found;
      logic pend_vld;
      logic out_free;
   } status_type;

endpackage

### rtl/cca_chan_if.sv
`timescale 1ns / 1ps

interface cca_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/coldest_core_allocator.sv
`timescale 1ns / 1ps

// channel   dir  payload               accepted when
// req_chan  in   cca_pkg::req_item_type valid && ready
// rsp_chan  out  cca_pkg::rsp_item_type valid && ready
// csr_chan  in   cca_pkg::csr_item_type valid && ready (ready held high)
//
// sample item: written into the temperature memory on accept. allocation: first counts the
//   available cores among the cores in use, then runs one coldest-core scan per granted core
// migrate item: checks each core in use, reads the temperature of each active one, runs a
//   coldest-core scan over the free cores for each hot active core, then emits a final result
// the temperature memory has a single read port, shared by the core checks and the scans;
//   the coldest-core scan reads one entry per cycle
// reset clears control and valid bits at once; no clearing pass is run
// a result waiting in the output register does not block the next item; emits stall
//   only while that register is still full

module coldest_core_allocator #(
   parameter int MAX_CORES = cca_pkg::MAX_CORES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cca_chan_if.sink   req_chan,
   cca_chan_if.source rsp_chan,
   cca_chan_if.sink   csr_chan
);

   cca_pkg::cmd_type    cmd;
   cca_pkg::status_type status;

   // configuration writes are always taken
   assign csr_chan.ready = 1'b1;

   // sequencer: accepts items, steps the scans, orders the results
   cca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.payload.req_type),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // temperature memory, masks, scan compare and output register
   cca_datapath #(
      .MAX_CORES (MAX_CORES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_chan.payload),
      .csr_valid (csr_chan.valid),
      .csr_item  (csr_chan.payload),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_item  (rsp_chan.payload),
      .cmd       (cmd),
      .status    (status)
   );

   // results are only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over a waiting result");

   // allocation and migrate items hold off the input side while they run
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready &&
       (req_chan.payload.req_type == cca_pkg::REQ_ALLOC ||
        req_chan.payload.req_type == cca_pkg::REQ_MIGRATE)) |=> !req_chan.ready)
      else $error("input accepted during a running request");

   // failure and nothing-to-report results are single, final and carry no cores
   a_single_results: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.payload.result_kind == cca_pkg::KIND_FAIL ||
                          rsp_chan.payload.result_kind == cca_pkg::KIND_NONE))
      |-> (rsp_chan.payload.last && rsp_chan.payload.target_core == '0 &&
           rsp_chan.payload.source_core == '0))
      else $error("malformed single result");

   // a grant never names a source core
   a_grant_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.result_kind == cca_pkg::KIND_GRANT)
      |-> (rsp_chan.payload.source_core == '0))
      else $error("grant with a source core");

endmodule

### rtl/cca_ctrl.sv
`timescale 1ns / 1ps

module cca_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_type,
   output logic                 req_ready,
   input  cca_pkg::status_type  status,
   output cca_pkg::cmd_type     cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_COUNT  = 9'b000000010,
      ST_PICK   = 9'b000000100,
      ST_GRANT  = 9'b000001000,
      ST_CHECK  = 9'b000010000,
      ST_TEST   = 9'b000100000,
      ST_MPICK  = 9'b001000000,
      ST_MSTORE = 9'b010000000,
      ST_FLUSH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.kind  = cca_pkg::KIND_NONE;
      cmd.sel   = cca_pkg::SEL_ZERO;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  cca_pkg::REQ_SAMPLE: cmd.accept_sample = 1'b1;
                  cca_pkg::REQ_ALLOC: begin
                     cmd.accept_alloc = 1'b1;
                     state_in = ST_COUNT;
                  end
                  cca_pkg::REQ_MIGRATE: begin
                     cmd.accept_migr = 1'b1;
                     state_in = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_COUNT: begin
            if (!status.scan_done) begin
               cmd.count_step = 1'b1;
            end else if (status.need_zero || !status.have_enough) begin
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.last = 1'b1;
                  cmd.kind = status.need_zero ? cca_pkg::KIND_NONE : cca_pkg::KIND_FAIL;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.scan_start = 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!status.scan_done) begin
               cmd.scan_step = 1'b1;
            end else begin
               state_in = ST_GRANT;
            end
         end
         ST_GRANT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.kind      = cca_pkg::KIND_GRANT;
               cmd.sel       = cca_pkg::SEL_BEST;
               cmd.last      = status.need_one;
               cmd.take_best = 1'b1;
               if (status.need_one) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in = ST_PICK;
               end
            end
         end
         ST_CHECK: begin
            if (status.core_end) begin
               state_in = ST_FLUSH;
            end else if (status.core_active) begin
               cmd.rd_core = 1'b1;
               state_in = ST_TEST;
            end else begin
               cmd.next_core = 1'b1;
            end
         end
         ST_TEST: begin
            if (status.hot) begin
               cmd.scan_start = 1'b1;
               state_in = ST_MPICK;
            end else begin
               cmd.next_core = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_MPICK: begin
            if (!status.scan_done) begin
               cmd.scan_step = 1'b1;
            end else if (status.found) begin
               state_in = ST_MSTORE;
            end else begin
               cmd.next_core = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_MSTORE: begin
            if (!status.pend_vld || status.out_free) begin
               cmd.emit       = status.pend_vld;
               cmd.kind       = cca_pkg::KIND_MIGRATE;
               cmd.sel        = cca_pkg::SEL_PEND;
               cmd.store_pend = 1'b1;
               cmd.next_core  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               if (status.pend_vld) begin
                  cmd.kind = cca_pkg::KIND_MIGRATE;
                  cmd.sel  = cca_pkg::SEL_PEND;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/cca_datapath.sv
`timescale 1ns / 1ps

module cca_datapath #(
   parameter int MAX_CORES = cca_pkg::MAX_CORES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cca_pkg::req_item_type req_item,
   input  logic                  csr_valid,
   input  cca_pkg::csr_item_type csr_item,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output cca_pkg::rsp_item_type rsp_item,
   input  cca_pkg::cmd_type      cmd,
   output cca_pkg::status_type   status
);

   localparam int IW = $clog2(MAX_CORES);
   localparam int CW = $clog2(MAX_CORES + 1);
   localparam int TW = cca_pkg::TEMP_W;
   localparam int NW = cca_pkg::CORE_COUNT_W;

   // temperature store, entries read as zero until first written
   logic [TW-1:0]        temp_mem [MAX_CORES];
   logic [MAX_CORES-1:0] tvalid_ff, tvalid_in;
   logic [TW-1:0]        mem_q_ff;
   logic                 vbit_q_ff;
   logic                 mem_we;
   logic [IW-1:0]        wr_addr, rd_addr;

   logic [NW-1:0]        core_count_ff, core_count_in;
   logic signed [TW-1:0] crit_ff, crit_in;

   logic [MAX_CORES-1:0] work_mask_ff, work_mask_in;
   logic [MAX_CORES-1:0] act_mask_ff, act_mask_in;
   logic [NW-1:0]        need_ff, need_in;
   logic [CW-1:0]        have_ff, have_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic signed [TW-1:0] best_t_ff, best_t_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        core_ff, core_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [IW-1:0]        pend_tgt_ff, pend_tgt_in;
   logic [IW-1:0]        pend_src_ff, pend_src_in;
   logic                 out_vld_ff, out_vld_in;
   cca_pkg::rsp_item_type out_ff, out_in;

   logic [CW-1:0]        n_w;
   logic                 scan_live;
   logic [IW-1:0]        scan_idx;
   logic signed [TW-1:0] rd_t;

   assign n_w = (core_count_ff > NW'(MAX_CORES)) ? CW'(MAX_CORES) : CW'(core_count_ff);
   assign scan_live = (scan_ff < n_w);
   assign scan_idx  = scan_ff[IW-1:0];
   assign rd_t      = vbit_q_ff ? $signed(mem_q_ff) : '0;
   assign rd_addr   = cmd.rd_core ? core_ff[IW-1:0] : scan_idx;
   assign wr_addr   = req_item.core_index[IW-1:0];
   assign mem_we    = cmd.accept_sample &&
                      ({1'b0, req_item.core_index} < NW'(MAX_CORES));

   always_comb begin
      tvalid_in     = tvalid_ff;
      core_count_in = core_count_ff;
      crit_in       = crit_ff;
      work_mask_in  = work_mask_ff;
      act_mask_in   = act_mask_ff;
      need_in       = need_ff;
      have_in       = have_ff;
      scan_in       = scan_ff;
      rd_vld_in     = rd_vld_ff;
      rd_idx_in     = rd_idx_ff;
      best_idx_in   = best_idx_ff;
      best_t_in     = best_t_ff;
      found_in      = found_ff;
      core_in       = core_ff;
      pend_vld_in   = pend_vld_ff;
      pend_tgt_in   = pend_tgt_ff;
      pend_src_in   = pend_src_ff;
      out_vld_in    = out_vld_ff;
      out_in        = out_ff;

      if (csr_valid) begin
         case (csr_item.index)
            cca_pkg::CSR_CORE_COUNT: core_count_in = csr_item.data[NW-1:0];
            cca_pkg::CSR_CRIT_TEMP:  crit_in = $signed(csr_item.data);
            default: ;
         endcase
      end

      if (mem_we) begin
         tvalid_in[wr_addr] = 1'b1;
      end

      // compare stage of the scan, one temperature behind the read
      if (rd_vld_ff && (!found_ff || (rd_t < best_t_ff))) begin
         best_idx_in = rd_idx_ff;
         best_t_in   = rd_t;
         found_in    = 1'b1;
      end

      if (cmd.accept_alloc) begin
         work_mask_in = req_item.available_mask[MAX_CORES-1:0];
         need_in      = req_item.core_requirement;
         have_in      = '0;
         scan_in      = '0;
         rd_vld_in    = 1'b0;
      end
      if (cmd.accept_migr) begin
         work_mask_in = req_item.free_mask[MAX_CORES-1:0];
         act_mask_in  = req_item.active_mask[MAX_CORES-1:0];
         core_in      = '0;
         pend_vld_in  = 1'b0;
         rd_vld_in    = 1'b0;
      end
      if (cmd.count_step && scan_live) begin
         have_in = have_ff + CW'(work_mask_ff[scan_idx]);
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.scan_step) begin
         if (scan_live) begin
            rd_vld_in = work_mask_ff[scan_idx];
            rd_idx_in = scan_idx;
            scan_in   = scan_ff + 1'b1;
         end else begin
            rd_vld_in = 1'b0;
         end
      end
      if (cmd.scan_start) begin
         scan_in   = '0;
         rd_vld_in = 1'b0;
         found_in  = 1'b0;
      end
      if (cmd.take_best) begin
         work_mask_in[best_idx_ff] = 1'b0;
         need_in = need_ff - 1'b1;
      end
      if (cmd.store_pend) begin
         work_mask_in[best_idx_ff] = 1'b0;
         pend_vld_in = 1'b1;
         pend_tgt_in = best_idx_ff;
         pend_src_in = core_ff[IW-1:0];
      end
      if (cmd.next_core) begin
         core_in = core_ff + 1'b1;
      end

      if (cmd.emit) begin
         out_vld_in         = 1'b1;
         out_in.result_kind = cmd.kind;
         out_in.last        = cmd.last;
         case (cmd.sel)
            cca_pkg::SEL_BEST: begin
               out_in.target_core = cca_pkg::CORE_IDX_W'(best_idx_ff);
               out_in.source_core = '0;
            end
            cca_pkg::SEL_PEND: begin
               out_in.target_core = cca_pkg::CORE_IDX_W'(pend_tgt_ff);
               out_in.source_core = cca_pkg::CORE_IDX_W'(pend_src_ff);
            end
            default: begin
               out_in.target_core = '0;
               out_in.source_core = '0;
            end
         endcase
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         temp_mem[wr_addr] <= req_item.temperature;
      end
      mem_q_ff <= temp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff     <= '0;
         core_count_ff <= cca_pkg::CORE_COUNT_RST;
         crit_ff       <= cca_pkg::CRIT_TEMP_RST;
         out_vld_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         pend_vld_ff   <= 1'b0;
      end else begin
         tvalid_ff     <= tvalid_in;
         core_count_ff <= core_count_in;
         crit_ff       <= crit_in;
         out_vld_ff    <= out_vld_in;
         rd_vld_ff     <= rd_vld_in;
         pend_vld_ff   <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      vbit_q_ff    <= tvalid_ff[rd_addr];
      work_mask_ff <= work_mask_in;
      act_mask_ff  <= act_mask_in;
      need_ff      <= need_in;
      have_ff      <= have_in;
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_t_ff    <= best_t_in;
      found_ff     <= found_in;
      core_ff      <= core_in;
      pend_tgt_ff  <= pend_tgt_in;
      pend_src_ff  <= pend_src_in;
      out_ff       <= out_in;
   end

   always_comb begin
      status.scan_done   = !scan_live && !rd_vld_ff;
      status.need_zero   = (need_ff == '0);
      status.need_one    = (need_ff == NW'(1));
      status.have_enough = (need_ff <= NW'(have_ff));
      status.core_end    = !(core_ff < n_w);
      status.core_active = act_mask_ff[core_ff[IW-1:0]];
      status.hot         = (rd_t > crit_ff);
      status.found       = found_ff;
      status.pend_vld    = pend_vld_ff;
      status.out_free    = !out_vld_ff || rsp_ready;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_ff;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import cca_pkg::*;

   localparam int MAX_CORES = MAX_CORES_DEF;
   localparam int CYCLE_LIMIT = 8_000_000;
   // an item with no result can still be in flight after the last result
   localparam int CALM_CYCLES = 2 * MAX_CORES + 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS = 44;
   localparam int NUM_PHASES = 7;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [MASK_W-1:0] ALL_CORES = '1;

   // one directed row: the item and, where obvious, its single result
   typedef struct packed {
      logic         typed;
      rsp_item_type want;
      req_item_type item;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cca_chan_if #(.payload_type(req_item_type)) req_chan ();
   cca_chan_if #(.payload_type(rsp_item_type)) rsp_chan ();
   cca_chan_if #(.payload_type(csr_item_type)) csr_chan ();

   coldest_core_allocator #(.MAX_CORES(MAX_CORES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: temperatures and register copies
   logic signed [TEMP_W-1:0] temp_store [MAX_CORES];
   logic [CORE_COUNT_W-1:0]  core_count_cfg;
   logic signed [TEMP_W-1:0] crit_cfg;

   // placements still owed by the block, oldest first
   rsp_item_type  due_placements[$];
   probe_row_type probe_rows[$];

   int  fault_count = 0;
   int  cycle_count = 0;
   int  hold_requests = 0;
   int  holds_done = 0;
   bit  sender_calm = 1'b0;

   function automatic void owe_result(input rsp_item_type r);
      due_placements.insert(due_placements.size(), r);
   endfunction

   function automatic void add_probe(input logic typed, input rsp_item_type want,
                                     input req_item_type item);
      probe_row_type row;
      row.typed = typed;
      row.want = want;
      row.item = item;
      probe_rows.insert(probe_rows.size(), row);
   endfunction

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int cores_in_use();
      return (core_count_cfg > MAX_CORES) ? MAX_CORES : int'(core_count_cfg);
   endfunction

   // coldest core set in pool, lowest index on ties, -1 when pool is empty
   function automatic int coldest_core_of(input logic [MASK_W-1:0] pool, input int n);
      int best;
      int c;
      logic signed [TEMP_W-1:0] best_t;
      best = -1;
      best_t = '0;
      for (c = 0; c < n; c++) begin
         if (pool[c] && (best < 0 || temp_store[c] < best_t)) begin
            best = c;
            best_t = temp_store[c];
         end
      end
      return best;
   endfunction

   function automatic rsp_item_type mk_rsp(input kind_type kind, input int tgt, input int src,
                                           input logic last);
      rsp_item_type r;
      r.result_kind = kind;
      r.target_core = tgt[CORE_IDX_W-1:0];
      r.source_core = src[CORE_IDX_W-1:0];
      r.last = last;
      return r;
   endfunction

   function automatic req_item_type mk_req(input logic [1:0] kind, input int idx, input int temp,
                                           input int need, input logic [MASK_W-1:0] avail,
                                           input logic [MASK_W-1:0] free_m,
                                           input logic [MASK_W-1:0] act);
      req_item_type it;
      it.req_type = kind;
      it.core_index = idx[CORE_IDX_W-1:0];
      it.temperature = temp[TEMP_W-1:0];
      it.core_requirement = need[CORE_COUNT_W-1:0];
      it.available_mask = avail;
      it.free_mask = free_m;
      it.active_mask = act;
      return it;
   endfunction

   // works out the placements one accepted item causes
   function automatic void predict_placement(input req_item_type it);
      int n, c, p, have, need;
      bit held_any;
      logic [MASK_W-1:0] in_use, pool, busy;
      rsp_item_type held;
      n = cores_in_use();
      in_use = '0;
      for (c = 0; c < n; c++) in_use[c] = 1'b1;
      held_any = 1'b0;
      held = '0;
      case (it.req_type)
         REQ_SAMPLE: temp_store[it.core_index] = it.temperature;
         REQ_ALLOC: begin
            pool = it.available_mask & in_use;
            have = 0;
            for (c = 0; c < n; c++) have += pool[c];
            need = it.core_requirement;
            if (need == 0) begin
               owe_result(mk_rsp(KIND_NONE, 0, 0, 1'b1));
            end else if (need > have) begin
               owe_result(mk_rsp(KIND_FAIL, 0, 0, 1'b1));
            end else begin
               for (c = 0; c < need; c++) begin
                  p = coldest_core_of(pool, n);
                  pool[p] = 1'b0;
                  owe_result(mk_rsp(KIND_GRANT, p, 0, c == need - 1));
               end
            end
         end
         REQ_MIGRATE: begin
            pool = it.free_mask & in_use;
            busy = it.active_mask & in_use;
            for (c = 0; c < n; c++) begin
               if (busy[c] && temp_store[c] > crit_cfg) begin
                  p = coldest_core_of(pool, n);
                  // hot core with no free target left is skipped
                  if (p >= 0) begin
                     pool[p] = 1'b0;
                     if (held_any) owe_result(held);
                     held = mk_rsp(KIND_MIGRATE, p, c, 1'b0);
                     held_any = 1'b1;
                  end
               end
            end
            if (held_any) begin
               held.last = 1'b1;
               owe_result(held);
            end else begin
               owe_result(mk_rsp(KIND_NONE, 0, 0, 1'b1));
            end
         end
         default: ;
      endcase
   endfunction

   task automatic compare_placement(input rsp_item_type got);
      rsp_item_type want;
      if (due_placements.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: unexpected item kind %0d target %0d source %0d last %0d",
                     $realtime, got.result_kind, got.target_core, got.source_core, got.last);
      end else begin
         want = due_placements.pop_front();
         if (got.result_kind !== want.result_kind || got.target_core !== want.target_core ||
             got.source_core !== want.source_core || got.last !== want.last) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: mismatch, want kind/target/source/last %0d %0d %0d %0d, %s",
                        $realtime, want.result_kind, want.target_core, want.source_core,
                        want.last, $sformatf("got %0d %0d %0d %0d", got.result_kind,
                        got.target_core, got.source_core, got.last));
         end
      end
   endtask

   function automatic logic [MASK_W-1:0] draw_mask();
      logic [MASK_W-1:0] a, b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return a & b;
         1: return a | b;
         2: return ALL_CORES;
         3: return a & b & {$urandom, $urandom};
         default: return a;
      endcase
   endfunction

   // random item, mostly meaningful for the cores in use
   function automatic req_item_type draw_item();
      req_item_type it;
      int n, roll, span, t;
      n = cores_in_use();
      it.req_type = REQ_SAMPLE;
      it.core_index = CORE_IDX_W'($urandom);
      it.temperature = TEMP_W'($urandom);
      it.core_requirement = CORE_COUNT_W'($urandom_range(0, MAX_CORES));
      it.available_mask = draw_mask();
      it.free_mask = draw_mask();
      it.active_mask = draw_mask();
      roll = $urandom_range(0, 99);
      if (roll < 42) begin
         if ($urandom_range(0, 7) != 0) it.core_index = CORE_IDX_W'($urandom_range(0, n - 1));
         // cluster samples around the threshold so migrations are mixed
         if ($urandom_range(0, 2) != 0) begin
            t = int'(crit_cfg) + int'($urandom_range(0, 64)) - 32;
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            it.temperature = t[TEMP_W-1:0];
         end
      end else if (roll < 72) begin
         it.req_type = REQ_ALLOC;
         span = (n > 6) ? 6 : n;
         case ($urandom_range(0, 19))
            0: it.core_requirement = '0;
            1: it.core_requirement = CORE_COUNT_W'($urandom_range(n, MAX_CORES));
            2, 3: it.core_requirement = CORE_COUNT_W'($urandom_range(1, n));
            default: it.core_requirement = CORE_COUNT_W'($urandom_range(1, span));
         endcase
      end else if (roll < 96) begin
         it.req_type = REQ_MIGRATE;
      end else begin
         it.req_type = REQ_UNUSED;
      end
      return it;
   endfunction

   // idle gap, then hold the item until the block takes it
   task automatic offer_item(input req_item_type it);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // always waits on the clock before it first checks the queue
   task automatic drain_results();
      do @(posedge clock); while (due_placements.size() != 0);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [TEMP_W-1:0] value);
      csr_item_type w;
      w.index = idx;
      w.data = value;
      csr_chan.valid <= 1'b1;
      csr_chan.payload <= w;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_CORE_COUNT: core_count_cfg = value[CORE_COUNT_W-1:0];
         CSR_CRIT_TEMP: crit_cfg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic run_phase(input int count, input bit squeeze);
      req_item_type it;
      int sent;
      sent = 0;
      // receiver holds off a long while so the block backs up into its input
      if (squeeze) hold_requests++;
      while (sent < count) begin
         it = draw_item();
         if (squeeze && sent < 24) sender_calm = 1'b1;
         else if ($urandom_range(0, 14) == 0) sender_calm = !sender_calm;
         offer_item(it);
         predict_placement(it);
         sent++;
         // sender pause until the block has caught up
         if (sent < count && $urandom_range(0, 29) == 0) begin
            req_chan.valid <= 1'b0;
            drain_results();
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   // result side: random stalls, calm stretches, one long hold-off on request
   initial begin : result_sink
      int stall;
      bit sink_calm;
      sink_calm = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < hold_requests) begin
            holds_done++;
            stall = HOLD_OFF_CYCLES;
         end else begin
            if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         compare_placement(rsp_chan.payload);
      end
   end

   initial begin : stimulus
      int i, n_cores, crit_pick;
      int phase_cores [NUM_PHASES];
      int phase_crit [NUM_PHASES];
      probe_row_type row;

      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.payload <= '0;

      // predictor after reset: cold store, register reset values
      for (i = 0; i < MAX_CORES; i++) temp_store[i] = '0;
      core_count_cfg = CORE_COUNT_RST;
      crit_cfg = CRIT_TEMP_RST;

      // directed probes, all at the reset register values
      // just after reset every core reads zero, so core 0 wins
      add_probe(1'b1, mk_rsp(KIND_GRANT, 0, 0, 1'b1),
                mk_req(REQ_ALLOC, 0, 0, 1, ALL_CORES, '0, '0));
      // zero requirement
      add_probe(1'b1, mk_rsp(KIND_NONE, 0, 0, 1'b1),
                mk_req(REQ_ALLOC, 0, 0, 0, ALL_CORES, '0, '0));
      // too few cores: all 64 wanted, one missing
      add_probe(1'b1, mk_rsp(KIND_FAIL, 0, 0, 1'b1),
                mk_req(REQ_ALLOC, 0, 0, 64, ~(64'd1 << 5), '0, '0));
      add_probe(1'b1, mk_rsp(KIND_FAIL, 0, 0, 1'b1),
                mk_req(REQ_ALLOC, 0, 0, 1, '0, '0, '0));
      // nothing hot yet, so nothing moves
      add_probe(1'b1, mk_rsp(KIND_NONE, 0, 0, 1'b1),
                mk_req(REQ_MIGRATE, 0, 0, 0, '0, ALL_CORES, ALL_CORES));
      // unused request type, index, temperature and masks all ones, no result
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_UNUSED, 63, -1, 64, ALL_CORES, ALL_CORES, ALL_CORES));
      // temperature extremes on the edge cores
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_SAMPLE, 63, -32768, 0, '0, '0, '0));
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_SAMPLE, 0, 32767, 0, '0, '0, '0));
      add_probe(1'b1, mk_rsp(KIND_GRANT, 63, 0, 1'b1),
                mk_req(REQ_ALLOC, 0, 0, 1, ALL_CORES, '0, '0));
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_ALLOC, 0, 0, 2, (64'd1 << 63) | 64'd1, '0, '0));
      // one unit above and exactly at the threshold
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_SAMPLE, 5, 1281, 0, '0, '0, '0));
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_SAMPLE, 6, 1280, 0, '0, '0, '0));
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_MIGRATE, 0, 0, 0, '0, (64'd1 << 63) | 64'h22, 64'h61));
      // self target: active and free core moves onto itself
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_MIGRATE, 0, 0, 0, '0, 64'h20, 64'h20));
      // second hot core finds no free target left
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_MIGRATE, 0, 0, 0, '0, 64'd1 << 63, 64'h21));
      add_probe(1'b1, mk_rsp(KIND_NONE, 0, 0, 1'b1),
                mk_req(REQ_MIGRATE, 0, 0, 0, '0, '0, ALL_CORES));
      // ties go to the lowest index
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_ALLOC, 0, 0, 3, 64'h1e, '0, '0));
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_SAMPLE, 7, -1, 0, '0, '0, '0));
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_ALLOC, 0, 0, 1, 64'h180, '0, '0));
      // every core granted in one request
      add_probe(1'b0, rsp_item_type'('0),
                mk_req(REQ_ALLOC, 0, 0, 64, ALL_CORES, '0, '0));

      // register settings per phase, extremes first
      phase_cores = '{8, 2, 16, 64, 5, 33, 64};
      phase_crit = '{0, -32768, 32767, 1280, 0, 0, 0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < probe_rows.size(); i++) begin
         row = probe_rows[i];
         if ($urandom_range(0, 5) == 0) sender_calm = !sender_calm;
         offer_item(row.item);
         if (row.typed) owe_result(row.want);
         else predict_placement(row.item);
      end
      req_chan.valid <= 1'b0;

      for (i = 0; i < NUM_PHASES; i++) begin
         // registers change only with the block idle
         drain_results();
         repeat (CALM_CYCLES) @(posedge clock);
         n_cores = phase_cores[i];
         crit_pick = (i < 4) ? phase_crit[i] : int'($urandom_range(0, 65535)) - 32768;
         write_register(CSR_CORE_COUNT, n_cores[TEMP_W-1:0]);
         write_register(CSR_CRIT_TEMP, crit_pick[TEMP_W-1:0]);
         run_phase(PHASE_ITEMS, i == 2);
      end

      drain_results();
      repeat (CALM_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
